/* src/gsu_pkg.sv */
// ----------------------------------------------------------------------------
// gsu_pkg
// Shared types and constants of the GSM 7-bit septet unpacker.
// ----------------------------------------------------------------------------
package gsu_pkg;

  // default character cap of one text
  localparam int MAX_TEXT_CHARS_DEF = 255;

  // most characters one octet can cause
  localparam int RES_MAX = 3;

  // depth of the job queue between front and back
  localparam int Q_DEPTH = 2;

  // one decoded octet: up to three characters and their end flags
  typedef struct packed {
    logic [1:0]                 count;
    logic [RES_MAX-1:0][6:0]    chars;
    logic [RES_MAX-1:0]         ends;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/gsu_in_if.sv */
// ----------------------------------------------------------------------------
// gsu_in_if
// Octet channel: valid/ready handshake with one packed octet and its flags.
// ----------------------------------------------------------------------------
interface gsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet;
  logic       first_octet;
  logic       final_octet;
  logic [7:0] text_limit;

  modport source (output valid, octet, first_octet, final_octet, text_limit,
                  input ready);
  modport sink   (input valid, octet, first_octet, final_octet, text_limit,
                  output ready);
endinterface

/* src/gsu_out_if.sv */
// ----------------------------------------------------------------------------
// gsu_out_if
// Character channel: valid/ready handshake with one unpacked character.
// ----------------------------------------------------------------------------
interface gsu_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       run_last;
  logic       text_end;

  modport source (output valid, character, run_last, text_end, input ready);
  modport sink   (input valid, character, run_last, text_end, output ready);
endinterface

/* src/gsu_front.sv */
// ----------------------------------------------------------------------------
// gsu_front
// Accepts octets, keeps the unpacking state and turns each octet into a job
// of zero to three characters.
// ----------------------------------------------------------------------------
module gsu_front #(
  parameter int MAX_TEXT_CHARS = gsu_pkg::MAX_TEXT_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  gsu_in_if.sink          in_if,
  input  gsu_pkg::q_stat_t q_stat,
  output logic            push,
  output gsu_pkg::job_t   job
);

  localparam logic [7:0] LIMIT_CAP =
    (MAX_TEXT_CHARS > 255) ? 8'd255 : 8'(MAX_TEXT_CHARS);

  logic [7:0] prev_r, prev_nxt;
  logic [2:0] carry_r, carry_nxt;
  logic [7:0] ce_r, ce_nxt;
  logic       lr_r, lr_nxt;
  logic       accept;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;

  // decode one octet against the held state
  always_comb begin
    logic [7:0] lim;
    logic [2:0] c;
    logic [7:0] ce;
    logic       lr;
    logic [1:0] n;
    logic [6:0] ch;
    lim = (in_if.text_limit > LIMIT_CAP) ? LIMIT_CAP : in_if.text_limit;
    c   = (carry_r == 3'd0) ? 3'd1 : carry_r;
    ce  = ce_r;
    lr  = lr_r;
    n   = 2'd0;
    job = '0;
    ch  = 7'(({in_if.octet, prev_r}) >> (4'd8 - {1'b0, c}));

    if (in_if.first_octet) begin
      // first character always goes out
      c  = 3'd1;
      ce = 8'd1;
      lr = (lim <= 8'd1);
      job.chars[0] = in_if.octet[6:0];
      job.ends[0]  = lr;
      n  = 2'd1;
    end else if (!lr) begin
      // joined character from this and the previous octet
      if (ce >= lim) begin
        lr = 1'b1;
      end else begin
        ce = 8'(ce + 8'd1);
        lr = (ce >= lim);
        job.chars[n] = ch;
        job.ends[n]  = lr;
        n  = 2'(n + 2'd1);
      end
      if (!lr) begin
        if (c == 3'd7) begin
          // carry wraps: whole second character in the low bits
          c = 3'd1;
          if (ce >= lim) begin
            lr = 1'b1;
          end else begin
            ce = 8'(ce + 8'd1);
            lr = (ce >= lim);
            job.chars[n] = in_if.octet[6:0];
            job.ends[n]  = lr;
            n  = 2'(n + 2'd1);
          end
        end else begin
          c = 3'(c + 3'd1);
        end
      end
    end

    // remainder character on the final octet
    if (in_if.final_octet && !lr && (ce < lim)) begin
      ce = 8'(ce + 8'd1);
      lr = (ce >= lim);
      job.chars[n] = 7'(in_if.octet >> (4'd8 - {1'b0, c}));
      job.ends[n]  = 1'b1;
      n  = 2'(n + 2'd1);
    end else if (in_if.final_octet && (n != 2'd0)) begin
      job.ends[2'(n - 2'd1)] = 1'b1;
    end

    job.count = n;
    prev_nxt  = in_if.octet;
    carry_nxt = c;
    ce_nxt    = ce;
    lr_nxt    = lr;
  end

  assign push = accept && (job.count != 2'd0);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 8'd0;
      carry_r <= 3'd1;
      ce_r    <= 8'd0;
      lr_r    <= 1'b0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      carry_r <= carry_nxt;
      ce_r    <= ce_nxt;
      lr_r    <= lr_nxt;
    end
  end

endmodule

/* src/gsu_queue.sv */
// ----------------------------------------------------------------------------
// gsu_queue
// Short job queue that decouples the octet front from the character back.
// ----------------------------------------------------------------------------
module gsu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gsu_pkg::job_t    wr_job,
  input  logic             pop,
  output gsu_pkg::job_t    head,
  output gsu_pkg::q_stat_t q_stat
);

  localparam int PW = (gsu_pkg::Q_DEPTH > 1) ? $clog2(gsu_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(gsu_pkg::Q_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(gsu_pkg::Q_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(gsu_pkg::Q_DEPTH - 1);

  gsu_pkg::job_t  mem_r [gsu_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign q_stat.full  = (cnt_r == DEPTH_C);
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_P) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_P) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

endmodule

/* src/gsu_back.sv */
// ----------------------------------------------------------------------------
// gsu_back
// Walks the head job of the queue and sends its characters one at a time.
// ----------------------------------------------------------------------------
module gsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gsu_pkg::job_t    head,
  input  gsu_pkg::q_stat_t q_stat,
  output logic             pop,
  gsu_out_if.source        out_if
);

  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       xfer;

  assign last = (idx_r == 2'(head.count - 2'd1));
  assign xfer = out_if.valid && out_if.ready;
  assign pop  = xfer && last;

  // result payload from the head job
  assign out_if.valid     = !q_stat.empty;
  assign out_if.character = head.chars[idx_r];
  assign out_if.run_last  = last;
  assign out_if.text_end  = head.ends[idx_r];

  // character index within the job
  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = last ? 2'd0 : 2'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

/* src/gsm7_septet_unpacker_core.sv */
// ----------------------------------------------------------------------------
// gsm7_septet_unpacker_core
// GSM 7-bit septet unpacker: packed octets in, 7-bit characters out.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one packed octet per transaction with first_octet,
//   final_octet and text_limit. out_if carries one character per
//   transaction with run_last on the last character of an octet and
//   text_end on the last character of the text.
//   The front decodes an octet in the cycle it is taken and queues a job of
//   zero to three characters; an octet that yields none leaves no trace on
//   out_if. The first character of a job is sent once the job reaches the queue head.
//   The back sends one character per cycle from the single result port
//   while out_if is ready; an octet yields up to three characters
//   (eight characters per seven octets for running text); octets are
//   taken every cycle while the two-entry job queue has room.
//   Reset (rst_n low at a clock edge) empties the queue and restores the
//   state: previous octet 0, carry 1, no characters counted.
//   When out_if stalls the head character holds and the queue fills; then
//   in_if.ready drops until a job has gone out.
// ----------------------------------------------------------------------------
module gsm7_septet_unpacker_core #(
  parameter int MAX_TEXT_CHARS = gsu_pkg::MAX_TEXT_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gsu_in_if.sink    in_if,
  gsu_out_if.source out_if
);

  gsu_pkg::job_t    fr_job;
  gsu_pkg::job_t    head;
  gsu_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  // octet decode and state
  gsu_front #(
    .MAX_TEXT_CHARS (MAX_TEXT_CHARS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_stat (q_stat),
    .push   (push),
    .job    (fr_job)
  );

  // job queue
  gsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (fr_job),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // character sender
  gsu_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

  // no job is written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // a queued job always has at least one character
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> (head.count != 2'd0))
    else $error("empty job at queue head");

  // a final octet that yields characters closes the text on its last one
  a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_if.final_octet) |-> fr_job.ends[2'(fr_job.count - 2'd1)])
    else $error("final octet job without text end");

  // popping happens only on the last character of the head job
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (out_if.valid && out_if.run_last))
    else $error("job popped before its last character");

endmodule
